### hw/rtl/ecpi_pkg.sv
// constants and control/status types shared by the palette indexer modules
// no dependencies
package ecpi_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int COLOR_W         = 24;
  localparam int BYTE_W          = 8;
  localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
  localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
  localparam int LIMIT_W         = 9;
  localparam int OUT_IDX_W       = 8;
  localparam int USED_W          = 9;
  localparam int CMP_W           = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

  // controller to datapath
  typedef struct packed {
    logic load;    // take a new item, reset the scan
    logic step;    // advance the scan by one entry
    logic finish;  // build the result and update the palette
  } ecpi_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic match;      // entry under compare equals the pixel
    logic exhausted;  // every live entry compared, none matched
  } ecpi_stat_t;

endpackage

### hw/rtl/ecpi_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ecpi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/ecpi_datapath.sv
// palette datapath: pixel register, entry count, scan pointer, palette ram, result register
// depends on ecpi_pkg and ecpi_ram
module ecpi_datapath import ecpi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ecpi_cmd_t            cmd,
  output ecpi_stat_t           stat,
  input  logic [BYTE_W-1:0]    first_byte,
  input  logic [BYTE_W-1:0]    second_byte,
  input  logic [BYTE_W-1:0]    third_byte,
  input  logic                 start_of_image,
  input  logic                 cfg_we,
  input  logic [LIMIT_W-1:0]   cfg_data,
  output logic [OUT_IDX_W-1:0] color_index,
  output logic                 new_entry,
  output logic                 palette_full_miss,
  output logic [USED_W-1:0]    entries_used
);

  logic [COLOR_W-1:0] color;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   scan;
  logic               pend;
  logic [IDX_W-1:0]   pend_idx;
  logic [LIMIT_W-1:0] limit;
  logic               scan_lt_n;
  logic               room;
  logic               ram_we;
  logic [COLOR_W-1:0] rd_data;

  assign scan_lt_n = scan < count;
  assign room      = (CMP_W'(count) < CMP_W'(limit))
                  && (CMP_W'(count) < CMP_W'(PALETTE_ENTRIES));

  assign stat.match     = pend && (rd_data == color);
  assign stat.exhausted = !pend && !scan_lt_n;

  assign ram_we = cmd.finish && !stat.match && room;

  ecpi_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PALETTE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (color),
    .rd_en   (cmd.step && scan_lt_n),
    .rd_addr (scan[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    count_next = count;
    if (cmd.load && start_of_image) begin
      count_next = '0;
    end else if (ram_we) begin
      count_next = CNT_W'(count + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      limit <= LIMIT_RESET;
      scan  <= '0;
      pend  <= 1'b0;
    end else begin
      count <= count_next;
      if (cfg_we) begin
        limit <= cfg_data;
      end
      if (cmd.load) begin
        scan <= '0;
        pend <= 1'b0;
      end else if (cmd.step) begin
        pend <= scan_lt_n;
        if (scan_lt_n) begin
          scan <= CNT_W'(scan + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      color <= {third_byte, second_byte, first_byte};
    end
    if (cmd.step) begin
      pend_idx <= scan[IDX_W-1:0];
    end
    if (cmd.finish) begin
      entries_used <= USED_W'(count_next);
      if (stat.match) begin
        color_index       <= OUT_IDX_W'(pend_idx);
        new_entry         <= 1'b0;
        palette_full_miss <= 1'b0;
      end else if (room) begin
        color_index       <= OUT_IDX_W'(count);
        new_entry         <= 1'b1;
        palette_full_miss <= 1'b0;
      end else begin
        color_index       <= '0;
        new_entry         <= 1'b0;
        palette_full_miss <= 1'b1;
      end
    end
  end

endmodule

### hw/rtl/ecpi_ctrl.sv
// controller: idle/scan sequencing and result valid flag
// depends on ecpi_pkg
module ecpi_ctrl import ecpi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  ecpi_stat_t stat,
  output ecpi_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state;
  logic state_next;
  logic out_free;
  logic done;

  assign out_free = !out_valid || !out_stall;
  assign done     = stat.match || stat.exhausted;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/exact_color_palette_indexer.sv
// exact-match palette indexer top level
// depends on ecpi_pkg, ecpi_ctrl, ecpi_datapath (which holds ecpi_ram)
//
// input channel: in_valid / in_stall with first_byte, second_byte, third_byte and
//   start_of_image; an item is taken when in_valid is high and in_stall is low
// output channel: out_valid / out_stall with color_index, new_entry,
//   palette_full_miss and entries_used; one result item per input item
// config channel: cfg_valid / cfg_ready with cfg_data, the palette limit;
//   cfg_ready is always high, write only while the block is idle
// timing: one item at a time; the palette ram is scanned one entry per cycle
//   through its single read port, so a hit finishes once its entry compares equal
//   and a miss once every live entry is compared; the block then goes back to
//   idle, where the next item is taken
// a new item is taken while the previous result still waits in the output register
// if the receiver stalls, a finished result holds and the scan waits before finishing
// reset: entry count cleared, limit back to 256, no result pending; palette ram
//   contents are not cleared, only entries below the count are ever compared
module exact_color_palette_indexer import ecpi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    first_byte,
  input  logic [BYTE_W-1:0]    second_byte,
  input  logic [BYTE_W-1:0]    third_byte,
  input  logic                 start_of_image,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_IDX_W-1:0] color_index,
  output logic                 new_entry,
  output logic                 palette_full_miss,
  output logic [USED_W-1:0]    entries_used,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  ecpi_cmd_t  cmd;
  ecpi_stat_t stat;

  // limit register is always writable
  assign cfg_ready = 1'b1;

  // sequencing: idle, then scan until hit or all live entries compared, finish once the output is free
  ecpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // palette storage, compare and result register
  ecpi_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .first_byte        (first_byte),
    .second_byte       (second_byte),
    .third_byte        (third_byte),
    .start_of_image    (start_of_image),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .color_index       (color_index),
    .new_entry         (new_entry),
    .palette_full_miss (palette_full_miss),
    .entries_used      (entries_used)
  );

  // a result is never both a new entry and a full miss
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(new_entry && palette_full_miss))
    else $error("new_entry and palette_full_miss both set");

  // a full miss always reports index zero
  a_full_miss_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && palette_full_miss) |-> (color_index == '0))
    else $error("full miss with nonzero index");

  // a new entry means the palette is not empty
  a_new_entry_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && new_entry) |-> (entries_used != '0))
    else $error("new entry reported with empty palette");

  // after an item is taken the block is busy scanning
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

endmodule

### dv/tb.sv
// self-checking testbench for exact_color_palette_indexer: directed pixels, full palette, random images
// depends on ecpi_pkg and the exact_color_palette_indexer rtl
module tb;
  import ecpi_pkg::*;

  // one pixel as offered on the input channel
  typedef struct packed {
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic [BYTE_W-1:0] third_byte;
    logic              start_of_image;
  } pixel_t;

  // one palette lookup outcome as seen on the output channel
  typedef struct packed {
    logic [OUT_IDX_W-1:0] color_index;
    logic                 new_entry;
    logic                 palette_full_miss;
    logic [USED_W-1:0]    entries_used;
  } index_result_t;

  localparam int TARGET_PIXELS = 800;
  localparam int HOLD_CYCLES   = 400;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    first_byte = '0;
  logic [BYTE_W-1:0]    second_byte = '0;
  logic [BYTE_W-1:0]    third_byte = '0;
  logic                 start_of_image = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_IDX_W-1:0] color_index;
  logic                 new_entry;
  logic                 palette_full_miss;
  logic [USED_W-1:0]    entries_used;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [LIMIT_W-1:0]   cfg_data = '0;

  // pixels waiting to be offered, lookups waiting to come out
  pixel_t        pixel_queue [$];
  index_result_t pending_lookups [$];

  // shadow copy of the palette and its control
  logic [COLOR_W-1:0] palette_shadow [PALETTE_ENTRIES];
  int unsigned        used_count;
  logic [LIMIT_W-1:0] limit_shadow;

  int  failures = 0;
  int  pixels_queued = 0;
  bit  calm = 1'b0;          // no random gaps and no random stalls while set
  bit  hold_request = 1'b0;  // asks the receiver for one long hold-off
  int  gap_left = 0;
  int  stall_left = 0;

  always #5 clk = ~clk;

  exact_color_palette_indexer dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .first_byte        (first_byte),
    .second_byte       (second_byte),
    .third_byte        (third_byte),
    .start_of_image    (start_of_image),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .color_index       (color_index),
    .new_entry         (new_entry),
    .palette_full_miss (palette_full_miss),
    .entries_used      (entries_used),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // exact-match lookup with first-come append, updates the shadow palette
  function automatic index_result_t index_pixel(pixel_t p);
    logic [COLOR_W-1:0] color;
    index_result_t      r;
    int unsigned        room;
    int unsigned        k;
    bit                 hit;
    color = {p.third_byte, p.second_byte, p.first_byte};
    r = '0;
    hit = 1'b0;
    if (p.start_of_image) used_count = 0;
    // lowest matching entry wins
    for (k = 0; k < used_count && !hit; k++) begin
      if (palette_shadow[k] == color) begin
        r.color_index = OUT_IDX_W'(k);
        hit = 1'b1;
      end
    end
    // a limit above the palette size counts as the palette size
    room = (limit_shadow > PALETTE_ENTRIES) ? PALETTE_ENTRIES : limit_shadow;
    if (!hit) begin
      if (used_count < room) begin
        palette_shadow[used_count] = color;
        r.color_index = OUT_IDX_W'(used_count);
        r.new_entry = 1'b1;
        used_count++;
      end else begin
        // full miss leaves the palette alone and reports index 0
        r.palette_full_miss = 1'b1;
      end
    end
    r.entries_used = USED_W'(used_count);
    return r;
  endfunction

  // sender: offers queued pixels, holds a stalled pixel steady
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        pixel_t p;
        p = pixel_queue.pop_front();
        first_byte     <= p.first_byte;
        second_byte    <= p.second_byte;
        third_byte     <= p.third_byte;
        start_of_image <= p.start_of_image;
        in_valid       <= 1'b1;
        gap_left = calm ? 0 : idle_length();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with a long hold-off on request counted here
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_length();
      end
    end
  end

  // scoreboard: check the result leaving, then predict the pixel entering
  always @(posedge clk) begin
    index_result_t want, got;
    if (rst) begin
      used_count = 0;
      limit_shadow = LIMIT_RESET;
      pending_lookups.delete();
    end else begin
      if (cfg_valid && cfg_ready) limit_shadow = cfg_data;
      if (out_valid && !out_stall) begin
        got = {color_index, new_entry, palette_full_miss, entries_used};
        if (pending_lookups.size() == 0) begin
          $error("result item with no pixel waiting: index %0d", got.color_index);
          failures++;
        end else begin
          want = pending_lookups.pop_front();
          if (got.color_index !== want.color_index) begin
            $error("color_index: expected %0d, actual %0d", want.color_index, got.color_index);
            failures++;
          end
          if (got.new_entry !== want.new_entry) begin
            $error("new_entry: expected %0d, actual %0d", want.new_entry, got.new_entry);
            failures++;
          end
          if (got.palette_full_miss !== want.palette_full_miss) begin
            $error("palette_full_miss: expected %0d, actual %0d",
                   want.palette_full_miss, got.palette_full_miss);
            failures++;
          end
          if (got.entries_used !== want.entries_used) begin
            $error("entries_used: expected %0d, actual %0d",
                   want.entries_used, got.entries_used);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall)
        pending_lookups.push_back(index_pixel({first_byte, second_byte, third_byte,
                                                start_of_image}));
    end
  end

  task automatic queue_pixel(logic [COLOR_W-1:0] color, logic sof);
    pixel_queue.push_back({color[7:0], color[15:8], color[23:16], sof});
    pixels_queued++;
  endtask

  // block is idle once every pixel went in and every lookup came out
  task automatic wait_drained();
    @(negedge clk);
    while (pixel_queue.size() != 0 || in_valid || pending_lookups.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // fill the palette to its last entry, then hit the last and random entries and miss on a full palette
  task automatic fill_palette();
    logic [COLOR_W-1:0] base;
    int j;
    base = COLOR_W'($urandom);
    for (j = 0; j < PALETTE_ENTRIES; j++)
      queue_pixel(base + COLOR_W'(j) * 24'h9e3779, j == 0);
    for (j = 0; j < 24; j++) begin
      if (j % 2 == 0)
        queue_pixel(base + COLOR_W'(j == 0 ? PALETTE_ENTRIES - 1 :
                    $urandom_range(0, PALETTE_ENTRIES - 1)) * 24'h9e3779, 1'b0);
      else
        queue_pixel(base + COLOR_W'(PALETTE_ENTRIES + j) * 24'h9e3779, 1'b0);
    end
    wait_drained();
  endtask

  // one phase: a limit, then a few images drawn from small color pools
  task automatic random_phase(int phase_no);
    logic [COLOR_W-1:0] pool [$];
    logic [COLOR_W-1:0] c;
    int images, pool_n, len, r, m, j;
    bit resume;
    case ($urandom_range(0, 9))
      0:       write_limit(LIMIT_W'(1));
      1:       write_limit(LIMIT_W'(2));
      2:       write_limit(LIMIT_W'(0));
      3:       write_limit(LIMIT_W'(256));
      4:       write_limit(LIMIT_W'(255));
      5:       write_limit(LIMIT_W'(511));
      6:       write_limit(LIMIT_W'(257));
      default: write_limit(LIMIT_W'($urandom_range(1, 64)));
    endcase
    // some phases carry on the previous image under the new limit
    resume = ($urandom_range(0, 3) == 0);
    calm = (phase_no % 5 == 1) || ($urandom_range(0, 4) == 0);
    images = $urandom_range(1, 3);
    for (m = 0; m < images; m++) begin
      pool.delete();
      pool_n = $urandom_range(1, 40);
      for (j = 0; j < pool_n; j++) begin
        // some pool colors sit one bit away from an earlier one
        if (j > 0 && $urandom_range(0, 3) == 0)
          pool.push_back(pool[$urandom_range(0, j - 1)] ^ (24'h1 << $urandom_range(0, 23)));
        else
          pool.push_back(COLOR_W'($urandom));
      end
      len = $urandom_range(4, 40);
      for (j = 0; j < len; j++) begin
        r = $urandom_range(0, 99);
        c = pool[$urandom_range(0, pool_n - 1)];
        if (r >= 80 && r < 90) c = COLOR_W'($urandom);
        else if (r >= 90) c = c ^ (24'h1 << $urandom_range(0, 23));
        queue_pixel(c, (j == 0 && !(m == 0 && resume)) || $urandom_range(0, 49) == 0);
      end
      // receiver holds off while the sender keeps pixels coming
      if (m == 0 && phase_no % 5 == 1) hold_request = 1'b1;
      // sender pauses until every lookup is back
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    calm = 1'b0;
    wait_drained();
  endtask

  initial begin
    int phase_no;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset limit, extreme colors, hits and appends
    queue_pixel(24'h000000, 1'b1);
    queue_pixel(24'hffffff, 1'b0);
    queue_pixel(24'h000000, 1'b0);
    queue_pixel(24'h0000ff, 1'b0);
    queue_pixel(24'h00ff00, 1'b0);
    queue_pixel(24'hff0000, 1'b0);
    queue_pixel(24'hffffff, 1'b0);
    queue_pixel(24'hff0000, 1'b0);
    // new image empties the palette
    queue_pixel(24'hffffff, 1'b1);
    queue_pixel(24'h000000, 1'b0);
    wait_drained();
    // limit reached mid-image: miss is a full miss, old entries still hit
    write_limit(LIMIT_W'(2));
    queue_pixel(24'h563412, 1'b0);
    queue_pixel(24'h000000, 1'b0);
    queue_pixel(24'hffffff, 1'b0);
    wait_drained();
    // zero limit: nothing is ever appended
    write_limit(LIMIT_W'(0));
    queue_pixel(24'hc35aa5, 1'b1);
    queue_pixel(24'h000000, 1'b0);
    wait_drained();
    write_limit(LIMIT_W'(3));
    queue_pixel(24'h030201, 1'b1);
    queue_pixel(24'h060504, 1'b0);
    queue_pixel(24'h090807, 1'b0);
    queue_pixel(24'h0c0b0a, 1'b0);
    wait_drained();
    // limit lowered below the entry count: entries stay matchable
    write_limit(LIMIT_W'(1));
    queue_pixel(24'h090807, 1'b0);
    queue_pixel(24'h0f0e0d, 1'b0);
    queue_pixel(24'h0f0e0d, 1'b1);
    queue_pixel(24'h030201, 1'b0);
    wait_drained();

    // limit above the palette size, palette filled to the top
    write_limit(LIMIT_W'(511));
    fill_palette();

    phase_no = 0;
    while (pixels_queued < TARGET_PIXELS) begin
      random_phase(phase_no);
      phase_no++;
    end

    wait_drained();
    repeat (PALETTE_ENTRIES + 8) @(posedge clk);
    if (failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
